// ===== design/lfr_pkg.sv =====
// Shared types and constants for the LRU frame replacer.
`default_nettype none
package lfr_pkg;

    localparam int FRAME_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int FRAME_MAX = 64;   // frames addressable by a 6-bit number

    localparam logic [1:0] REQ_VICTIM = 2'd0;
    localparam logic [1:0] REQ_PIN    = 2'd1;
    localparam logic [1:0] REQ_UNPIN  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_REMOVE,
        OP_APPEND
    } op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                 apply;
        op_t                  op;
        logic [FRAME_W-1:0]   frame;
        logic [COUNT_W-1:0]   pos;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/lfr_cell.sv =====
// One slot of the recency chain: holds a frame number, shifts or loads on command.
`default_nettype none
module lfr_cell #(
    parameter int IDX = 0
) (
    input  wire                                clk,
    input  lfr_pkg::cell_ctrl_t                ctrl,
    input  wire  [lfr_pkg::FRAME_W-1:0]        probe_frame,
    input  wire  [lfr_pkg::COUNT_W-1:0]        len,
    input  wire  [lfr_pkg::FRAME_W-1:0]        right_frame,
    output logic [lfr_pkg::FRAME_W-1:0]        frame,
    output logic                               hit
);
    import lfr_pkg::*;

    localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(IDX);

    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;

    always_comb
    begin
        frame_next = frame_reg;
        if (ctrl.apply)
        begin
            case (ctrl.op)
                OP_REMOVE:
                begin
                    // close the gap: everything from the removed slot up moves down
                    if (IDX_C >= ctrl.pos)
                        frame_next = right_frame;
                end
                OP_APPEND:
                begin
                    if (IDX_C == ctrl.pos)
                        frame_next = ctrl.frame;
                end
                default:
                begin
                    frame_next = frame_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame = frame_reg;
    assign hit   = (IDX_C < len) && (frame_reg == probe_frame);

endmodule
`default_nettype wire

// ===== design/lru_frame_replacer_core.sv =====
// Top level of the LRU frame replacer: cell chain, lookup and request control.
//
// LRU frame replacer. Keeps the evictable frames in a chain of cells, oldest
// in cell 0, newest at cell count-1. A request is a transfer on s_axis:
// victim pops cell 0, pin removes a listed frame (cells above it shift down
// one place), unpin appends an unlisted frame at the newest end. Exactly one
// result transfer leaves on m_axis per request, with the evictable count after
// the request. In the accept cycle every cell compares its frame against the
// request in parallel and the hit position is encoded and registered; then, in
// the apply state, the whole chain shifts or loads at once and the result lands
// in the output register. A stalled m_axis holds the apply state until the
// output register frees up; a waiting result does not block the next request
// from being accepted, but no new request is accepted until the last one is
// applied. Chain length is min(NUM_FRAMES, 64), since only 6-bit frame numbers
// below NUM_FRAMES can be listed. Frames at or above NUM_FRAMES and request
// code 3 change nothing. No clearing pass: the listed mask resets at once, and
// cells above the count are never read.
`default_nettype none
module lru_frame_replacer_core #(
    parameter int NUM_FRAMES = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [1:0] req_type, [7:2] frame_in
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] victim_found, [6:1] victim_frame,
                                        // [13:7] evictable_count, [15:14] zero
);
    import lfr_pkg::*;

    localparam int CELLS = (NUM_FRAMES < FRAME_MAX) ? NUM_FRAMES : FRAME_MAX;
    localparam logic [COUNT_W-1:0] CELLS_C = COUNT_W'(CELLS);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t               state_reg;
    logic [FRAME_MAX-1:0] mask_reg;
    logic [COUNT_W-1:0]   len_reg;
    op_t                  op_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [COUNT_W-1:0]   pos_reg;
    logic                 found_reg;
    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [FRAME_W-1:0]   out_frame_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic [1:0]           req;
    logic [FRAME_W-1:0]   frame_in;
    logic                 accept;
    logic                 frame_ok;
    logic                 apply_en;
    logic [CELLS-1:0]     hit_vec;
    logic [FRAME_W-1:0]   cell_frame [CELLS];
    logic [COUNT_W-1:0]   hit_pos;
    op_t                  op_next;
    logic [FRAME_W-1:0]   frame_next;
    logic [COUNT_W-1:0]   pos_next;
    logic                 found_next;
    cell_ctrl_t           cell_ctrl;

    assign req      = s_axis_tdata[1:0];
    assign frame_in = s_axis_tdata[7:2];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign frame_ok = (32'(frame_in) < NUM_FRAMES);

    // apply waits only while the previous result is still unclaimed
    assign apply_en = (state_reg == S_APPLY) && (!out_valid_reg || m_axis_tready);

    assign cell_ctrl = '{apply: apply_en, op: op_reg, frame: frame_reg, pos: pos_reg};

    // cell chain; the top cell shifts in don't-care data
    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            logic [FRAME_W-1:0] right;
            if (g == CELLS - 1)
            begin : g_end
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = cell_frame[g+1];
            end
            lfr_cell #(
                .IDX (g)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .probe_frame (frame_in),
                .len         (len_reg),
                .right_frame (right),
                .frame       (cell_frame[g]),
                .hit         (hit_vec[g])
            );
        end
    endgenerate

    // one-hot hit to position; listed frames are unique
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            if (hit_vec[i])
                hit_pos = hit_pos | COUNT_W'(i);
        end
    end

    // request decode at accept
    always_comb
    begin
        op_next    = OP_NONE;
        frame_next = frame_in;
        pos_next   = '0;
        found_next = 1'b0;
        case (req)
            REQ_VICTIM:
            begin
                if (len_reg != '0)
                begin
                    op_next    = OP_REMOVE;
                    frame_next = cell_frame[0];
                    found_next = 1'b1;
                end
            end
            REQ_PIN:
            begin
                if (frame_ok && mask_reg[frame_in])
                begin
                    op_next  = OP_REMOVE;
                    pos_next = hit_pos;
                end
            end
            REQ_UNPIN:
            begin
                if (frame_ok && !mask_reg[frame_in] && (len_reg < CELLS_C))
                begin
                    op_next  = OP_APPEND;
                    pos_next = len_reg;
                end
            end
            default:
            begin
                op_next = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mask_reg      <= '0;
            len_reg       <= '0;
            op_reg        <= OP_NONE;
            frame_reg     <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_frame_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            // claimed result with no new one behind it empties the output
            if (out_valid_reg && m_axis_tready && !apply_en)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= op_next;
                        frame_reg <= frame_next;
                        pos_reg   <= pos_next;
                        found_reg <= found_next;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (apply_en)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_frame_reg <= found_reg ? frame_reg : '0;
                        case (op_reg)
                            OP_REMOVE:
                            begin
                                mask_reg[frame_reg] <= 1'b0;
                                len_reg             <= len_reg - 1'b1;
                                out_count_reg       <= len_reg - 1'b1;
                            end
                            OP_APPEND:
                            begin
                                mask_reg[frame_reg] <= 1'b1;
                                len_reg             <= len_reg + 1'b1;
                                out_count_reg       <= len_reg + 1'b1;
                            end
                            default:
                            begin
                                out_count_reg <= len_reg;
                            end
                        endcase
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg, out_frame_reg, out_found_reg};

    // chain never overfills
    assert property (@(posedge clk) disable iff (!rst_n) len_reg <= CELLS_C)
        else $error("list length beyond chain");

    // listed mask and count agree
    assert property (@(posedge clk) disable iff (!rst_n)
        COUNT_W'($countones(mask_reg)) == len_reg)
        else $error("listed mask out of step with count");

    // a pin of a listed frame finds exactly one cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req == REQ_PIN && frame_ok && mask_reg[frame_in]) |-> $onehot(hit_vec))
        else $error("pin lookup did not hit exactly one cell");

    // a removal shortens the list by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (apply_en && op_reg == OP_REMOVE) |=> len_reg == $past(len_reg) - 1'b1)
        else $error("removal did not shorten the list");

endmodule
`default_nettype wire
